@@ hw/rtl/cht_pkg.sv @@
package cht_pkg;

    // Field widths of the two channels.
    localparam int COORD_W = 32;
    localparam int SLOT_W  = 7;

    // One table word: valid flag over the packed cell, x in the upper half.
    localparam int CELL_W = 2 * COORD_W;
    localparam int WORD_W = CELL_W + 1;

    // Hash multipliers, held as signed 28-bit constants.
    localparam int KEY_K_W = 28;
    localparam logic signed [KEY_K_W-1:0] HASH_KX = 28'sd73856093;
    localparam logic signed [KEY_K_W-1:0] HASH_KY = 28'sd19349669;

    // Product and hash width, and the digit size of the remainder unit.
    localparam int HASH_W    = COORD_W + KEY_K_W;
    localparam int DIGIT_W   = 4;
    localparam int DIGIT_CNT = HASH_W / DIGIT_W;
    localparam int DIGIT_CW  = $clog2(DIGIT_CNT);

    // Command codes.
    localparam logic CMD_RECENTER = 1'b0;
    localparam logic CMD_LOOKUP   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EV_RD,
        ST_EV_CHK,
        ST_HASH_START,
        ST_HASH_WAIT,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_MULX,
        HS_MULY,
        HS_MAG,
        HS_DIV,
        HS_FIX
    } hash_state_t;

endpackage

@@ hw/rtl/chunk_residency_hash_table.sv @@
// Residency table for the grid cells around a moving centre.
// The input channel (s_valid/s_ready) takes one word per command:
// s_command selects a recenter on (s_cell_x, s_cell_y) or a lookup of that
// cell. The result channel (m_valid/m_ready) returns exactly one word per
// command: m_found and m_slot for a lookup, m_overflow for a recenter.
// One command is worked on at a time; s_ready is high only while idle.
// A lookup runs the hash unit (one multiplier, then a 4-bit-per-cycle
// remainder), then reads and checks each probed slot in the table memory,
// which has one read port and one write port.
// A recenter first sweeps every slot for eviction, then hashes and probes
// for each of the (2*RADIUS+1)^2 window cells in turn.
// After reset the block clears the table memory, one slot per cycle;
// s_ready stays low until that pass is done.
// The result sits in an output register: if the receiver stalls, the next
// command is still accepted and worked on, and only its own result waits
// until the previous one has been taken.
module chunk_residency_hash_table
    import cht_pkg::*;
#(
    parameter int SLOTS  = 81,
    parameter int RADIUS = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic signed [COORD_W-1:0] s_cell_x,
    input  logic signed [COORD_W-1:0] s_cell_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic [SLOT_W-1:0]         m_slot,
    output logic                      m_overflow
);

    localparam int SW   = $clog2(SLOTS);
    localparam int SPAN = 2 * RADIUS;
    localparam int CW   = $clog2(SPAN + 1);
    localparam logic signed [COORD_W-1:0] RAD_P = COORD_W'(RADIUS);
    localparam logic signed [COORD_W-1:0] RAD_N = -RAD_P;

    ctrl_state_t state_reg, state_next;

    logic               op_reg, op_next;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [COORD_W-1:0] key_x_reg, key_x_next;
    logic [COORD_W-1:0] key_y_reg, key_y_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [SW-1:0]      idx_reg, idx_next;
    logic [SW-1:0]      start_reg, start_next;
    logic               ovf_reg, ovf_next;
    logic               res_found_reg, res_found_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;

    logic               m_valid_reg;
    logic               m_found_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic               m_overflow_reg;
    logic               out_load;

    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [SW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic               hash_start;
    logic               hash_done;
    logic [SW-1:0]      hash_home;

    logic               rd_valid;
    logic               key_match;
    logic [SW-1:0]      idx_inc;
    logic signed [COORD_W-1:0] dx, dy;
    logic               far;
    logic               last_j, last_i;

    // Table memory: {valid, x, y} per slot.
    cht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cht_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .x       (key_x_reg),
        .y       (key_y_reg),
        .done    (hash_done),
        .home    (hash_home)
    );

    assign rd_valid  = ram_rdata[WORD_W-1];
    assign key_match = (ram_rdata[CELL_W-1:0] == {key_x_reg, key_y_reg});
    assign idx_inc   = (idx_reg == SW'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;

    // Eviction distance on a torus: the wrapped difference must lie in
    // [-RADIUS, RADIUS] on both axes for the slot to stay.
    assign dx  = ram_rdata[CELL_W-1:COORD_W] - cx_reg;
    assign dy  = ram_rdata[COORD_W-1:0] - cy_reg;
    assign far = (dx > RAD_P) || (dx < RAD_N) || (dy > RAD_P) || (dy < RAD_N);

    assign last_j = (j_reg == CW'(SPAN));
    assign last_i = (i_reg == CW'(SPAN));

    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_slot     = m_slot_reg;
    assign m_overflow = m_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        key_x_reg     <= key_x_next;
        key_y_reg     <= key_y_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        start_reg     <= start_next;
        ovf_reg       <= ovf_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
    end

    // Output register: a finished result waits here for the receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg    <= res_found_reg;
            m_slot_reg     <= res_slot_reg;
            m_overflow_reg <= (op_reg == CMD_RECENTER) ? ovf_reg : 1'b0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        key_x_next     = key_x_reg;
        key_y_next     = key_y_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        ovf_next       = ovf_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        ram_raddr      = idx_reg;
        hash_start     = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                // Clearing pass after reset: one slot per cycle.
                ram_we = 1'b1;
                if (idx_reg == SW'(SLOTS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_command;
                    cx_next        = s_cell_x;
                    cy_next        = s_cell_y;
                    ovf_next       = 1'b0;
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                    idx_next       = '0;
                    if (s_command == CMD_RECENTER) begin
                        state_next = ST_EV_RD;
                    end else begin
                        key_x_next = s_cell_x;
                        key_y_next = s_cell_y;
                        state_next = ST_HASH_START;
                    end
                end
            end

            ST_EV_RD: state_next = ST_EV_CHK;

            ST_EV_CHK: begin
                if (rd_valid && far) begin
                    ram_we = 1'b1;
                end
                if (idx_reg == SW'(SLOTS - 1)) begin
                    // Sweep done; start inserting the window, x-major.
                    i_next     = '0;
                    j_next     = '0;
                    key_x_next = cx_reg - RAD_P;
                    key_y_next = cy_reg - RAD_P;
                    state_next = ST_HASH_START;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EV_RD;
                end
            end

            ST_HASH_START: begin
                hash_start = 1'b1;
                state_next = ST_HASH_WAIT;
            end

            ST_HASH_WAIT: begin
                if (hash_done) begin
                    idx_next   = hash_home;
                    start_next = hash_home;
                    state_next = ST_PROBE_RD;
                end
            end

            ST_PROBE_RD: state_next = ST_PROBE_CHK;

            ST_PROBE_CHK: begin
                if (op_reg == CMD_RECENTER) begin
                    if (!rd_valid || key_match || idx_inc == start_reg) begin
                        // Store the cell here, or on a full lap overwrite the
                        // home slot and flag the overflow.
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, key_x_reg, key_y_reg};
                        if (rd_valid && !key_match) begin
                            ram_waddr = start_reg;
                            ovf_next  = 1'b1;
                        end
                        if (last_j) begin
                            j_next     = '0;
                            i_next     = i_reg + 1'b1;
                            key_y_next = cy_reg - RAD_P;
                            key_x_next = key_x_reg + 1'b1;
                        end else begin
                            j_next     = j_reg + 1'b1;
                            key_y_next = key_y_reg + 1'b1;
                        end
                        state_next = (last_j && last_i) ? ST_FINISH : ST_HASH_START;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_PROBE_RD;
                    end
                end else begin
                    if (rd_valid && key_match) begin
                        res_found_next = 1'b1;
                        res_slot_next  = idx_reg[SLOT_W-1:0];
                        state_next     = ST_FINISH;
                    end else if (!rd_valid || idx_inc == start_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_PROBE_RD;
                    end
                end
            end

            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/cht_ram.sv @@
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cht_hash.sv @@
module cht_hash
    import cht_pkg::*;
#(
    parameter int SLOTS = 81
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [COORD_W-1:0]   x,
    input  logic signed [COORD_W-1:0]   y,
    output logic                        done,
    output logic [$clog2(SLOTS)-1:0]    home
);

    localparam int SW = $clog2(SLOTS);

    hash_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic signed [HASH_W-1:0]  px_reg;
    logic signed [HASH_W-1:0]  prod;
    logic signed [COORD_W-1:0] mul_a;
    logic signed [KEY_K_W-1:0] mul_k;
    logic [HASH_W-1:0]         h;
    logic [HASH_W-1:0]         mag_reg;
    logic                      neg_reg;
    logic [SW-1:0]             rem_reg;
    logic [SW-1:0]             rem_step;
    logic [SW-1:0]             r;
    logic [SW:0]               t;
    logic [DIGIT_CW-1:0]       dig_reg;

    // One multiplier, shared between the two coordinates.
    assign mul_a = (state_reg == HS_MULX) ? x_reg : y_reg;
    assign mul_k = (state_reg == HS_MULX) ? HASH_KX : HASH_KY;
    assign prod  = mul_a * mul_k;
    assign h     = px_reg ^ prod;

    // Four restoring remainder steps per cycle, most significant digit first.
    always_comb begin
        r = rem_reg;
        t = '0;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            t = {r, mag_reg[HASH_W-DIGIT_W+b]};
            if (t >= (SW+1)'(SLOTS)) begin
                t = t - (SW+1)'(SLOTS);
            end
            r = t[SW-1:0];
        end
        rem_step = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        home       = '0;
        case (state_reg)
            HS_IDLE: begin
                if (start) begin
                    state_next = HS_MULX;
                end
            end
            HS_MULX: state_next = HS_MULY;
            HS_MULY: state_next = HS_MAG;
            HS_MAG:  state_next = HS_DIV;
            HS_DIV: begin
                if (dig_reg == DIGIT_CW'(DIGIT_CNT - 1)) begin
                    state_next = HS_FIX;
                end
            end
            HS_FIX: begin
                done       = 1'b1;
                state_next = HS_IDLE;
                if (rem_reg == '0) begin
                    home = '0;
                end else if (neg_reg) begin
                    home = SW'(SLOTS) - rem_reg;
                end else begin
                    home = rem_reg;
                end
            end
            default: state_next = HS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            HS_IDLE: begin
                x_reg <= x;
                y_reg <= y;
            end
            HS_MULX: px_reg <= prod;
            HS_MULY: begin
                // The y product is folded in as it leaves the multiplier.
                neg_reg <= h[HASH_W-1];
                mag_reg <= h[HASH_W-1] ? (~h + HASH_W'(1)) : h;
            end
            HS_MAG: begin
                rem_reg <= '0;
                dig_reg <= '0;
            end
            HS_DIV: begin
                rem_reg <= rem_step;
                mag_reg <= mag_reg << DIGIT_W;
                dig_reg <= dig_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/cht_checker.sv @@
module cht_checker
    import cht_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_command,
    input logic signed [COORD_W-1:0] s_cell_x,
    input logic signed [COORD_W-1:0] s_cell_y,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_found,
    input logic [SLOT_W-1:0]         m_slot,
    input logic                      m_overflow
);

    // Reset starts the clearing pass: nothing is taken or offered.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    // One command at a time: after a word is taken the block is busy.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an accept");

    // A stalled result word holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_slot)
            && $stable(m_overflow))
        else $error("stalled result word changed");

    // A found cell comes from a lookup, which never flags overflow.
    a_found_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_overflow)
        else $error("found and overflow both set");

    // A miss or a recenter reports slot zero.
    a_miss_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_slot == '0)
        else $error("nonzero slot without a hit");

endmodule

bind chunk_residency_hash_table cht_checker u_cht_checker (.*);

@@ dv/tb.sv @@
import cht_pkg::*;

// Hash multipliers of the home-slot function.
localparam longint HOME_KX = 73856093;
localparam longint HOME_KY = 19349669;

// Shadow copy of the residency table. Every accepted command word is applied
// to it at once, and the reply that the command must produce is queued.
class residency_mirror #(int SLOTS = 81, int RADIUS = 4);
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              overflow;
    } reply_t;

    bit        live [SLOTS];
    bit [63:0] held_key [SLOTS];
    reply_t    due [$];
    int        bad_words = 0;

    // Signed 64-bit product hash, reduced to a non-negative slot index.
    function int unsigned home_of(bit [31:0] x, bit [31:0] y);
        longint    px;
        longint    py;
        bit [63:0] h;
        bit [63:0] rem;
        px = longint'($signed(x)) * HOME_KX;
        py = longint'($signed(y)) * HOME_KY;
        h = px ^ py;
        if (h[63]) begin
            rem = (~h + 64'd1) % 64'(SLOTS);
            return (rem == 64'd0) ? 0 : SLOTS - int'(rem);
        end
        return int'(h % 64'(SLOTS));
    endfunction

    // True when two coordinates lie more than RADIUS apart on the 32-bit ring.
    function bit out_of_reach(bit [31:0] a, bit [31:0] b);
        bit [31:0] d;
        d = a - b;
        if (d[31]) begin
            d = -d;
        end
        return d > 32'(RADIUS);
    endfunction

    // Linear-probe insert; returns 1 when the probe came back to the home slot.
    function bit place(bit [31:0] x, bit [31:0] y);
        bit [63:0]   key;
        int unsigned home;
        int unsigned idx;
        bit          wrapped;
        key = {x, y};
        home = home_of(x, y);
        idx = home;
        wrapped = 1'b0;
        while (live[idx] && held_key[idx] != key) begin
            idx = (idx + 1) % SLOTS;
            if (idx == home) begin
                wrapped = 1'b1;
                break;
            end
        end
        held_key[idx] = key;
        live[idx] = 1'b1;
        return wrapped;
    endfunction

    function void note_command(logic cmd, bit [31:0] x, bit [31:0] y);
        reply_t      r;
        bit [63:0]   key;
        int unsigned home;
        int unsigned idx;
        r = '0;
        if (cmd == CMD_RECENTER) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (live[i] && (out_of_reach(held_key[i][63:32], x) ||
                                out_of_reach(held_key[i][31:0], y))) begin
                    live[i] = 1'b0;
                end
            end
            for (int i = 0; i <= 2 * RADIUS; i++) begin
                for (int j = 0; j <= 2 * RADIUS; j++) begin
                    if (place(x - 32'(RADIUS) + 32'(i), y - 32'(RADIUS) + 32'(j))) begin
                        r.overflow = 1'b1;
                    end
                end
            end
        end else begin
            key = {x, y};
            home = home_of(x, y);
            idx = home;
            while (live[idx]) begin
                if (held_key[idx] == key) begin
                    r.found = 1'b1;
                    r.slot = SLOT_W'(idx);
                    break;
                end
                idx = (idx + 1) % SLOTS;
                if (idx == home) begin
                    break;
                end
            end
        end
        due.push_back(r);
    endfunction

    function void check_reply(logic found, logic [SLOT_W-1:0] slot, logic overflow);
        reply_t want;
        if (due.size() == 0) begin
            if (bad_words < 10) begin
                $display("reply with none pending: found=%b slot=%0d overflow=%b",
                         found, slot, overflow);
            end
            bad_words++;
            return;
        end
        want = due.pop_front();
        if (found !== want.found || slot !== want.slot || overflow !== want.overflow) begin
            if (bad_words < 10) begin
                $display("reply mismatch: expected found=%b slot=%0d overflow=%b, got found=%b slot=%0d overflow=%b",
                         want.found, want.slot, want.overflow, found, slot, overflow);
            end
            bad_words++;
        end
    endfunction
endclass

module tb;

    localparam int N_SLOTS  = 81;
    localparam int N_RADIUS = 4;

    // Generous ceiling: it covers recenters whose every insert probes the whole
    // table, full-lap lookups and the random stalls on each word. The worst mix
    // of the run stays well below a quarter of this.
    localparam int unsigned CYCLE_LIMIT = 8_000_000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_command;
    logic signed [COORD_W-1:0] s_cell_x;
    logic signed [COORD_W-1:0] s_cell_y;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_found;
    logic [SLOT_W-1:0]         m_slot;
    logic                      m_overflow;

    residency_mirror #(.SLOTS(N_SLOTS), .RADIUS(N_RADIUS)) mirror;

    // Percent chance, per cycle, that the sender holds back a word or the
    // receiver drops m_ready. The stimulus process changes them by phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;

    // Centre of the window most recently requested, used to aim lookups and
    // small recenter shifts so that most words land on resident cells.
    logic [31:0] ctr_x = '0;
    logic [31:0] ctr_y = '0;

    chunk_residency_hash_table #(
        .SLOTS  (N_SLOTS),
        .RADIUS (N_RADIUS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_cell_x   (s_cell_x),
        .s_cell_y   (s_cell_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_found    (m_found),
        .m_slot     (m_slot),
        .m_overflow (m_overflow)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side. Values sampled right after the edge are the ones that held
    // before it, so a word counts as taken when m_valid and m_ready were both
    // high going into this edge. m_ready is then redrawn for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            mirror.check_reply(m_found, m_slot, m_overflow);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog against a hung block.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Small signed offset in -span..span, wrapped to 32 bits.
    function automatic logic [31:0] jitter(int unsigned span);
        return 32'($urandom_range(2 * span)) - 32'(span);
    endfunction

    // A coordinate close to one of the interesting points of the 32-bit ring:
    // zero, minus one and both sides of the signed wrap.
    function automatic logic [31:0] near_corner();
        logic [31:0] base;
        case ($urandom_range(3))
            0: begin
                base = 32'h0000_0000;
            end
            1: begin
                base = 32'h7FFF_FFFF;
            end
            2: begin
                base = 32'h8000_0000;
            end
            default: begin
                base = 32'hFFFF_FFFF;
            end
        endcase
        return base + jitter(6);
    endfunction

    // Offers one command word and returns at the edge where it is taken.
    // s_valid is only lowered while the sender chooses to idle, so a word
    // that follows directly keeps valid high without a glitch.
    task automatic send_command(input logic cmd, input logic [31:0] x,
                                input logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_cell_x  <= x;
        s_cell_y  <= y;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        mirror.note_command(cmd, x, y);
        if (cmd == CMD_RECENTER) begin
            ctr_x = x;
            ctr_y = y;
        end
    endtask

    // Random words. Recenters are kept rare because each one sweeps the table
    // and refills the whole window. Most recenters nudge the window so that
    // part of it survives and resident cells get re-inserted; the rest jump
    // anywhere, often close to the wrap points. Most lookups aim around the
    // current centre, just inside and just outside the window, so that hits
    // at various probe depths and full-lap misses both occur often.
    task automatic run_random(int count);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(19);
            if ($urandom_range(99) < 6) begin
                if (pick < 12) begin
                    send_command(CMD_RECENTER, ctr_x + jitter(5), ctr_y + jitter(5));
                end else if (pick < 16) begin
                    send_command(CMD_RECENTER, $urandom, $urandom);
                end else begin
                    send_command(CMD_RECENTER, near_corner(), near_corner());
                end
            end else begin
                if (pick < 14) begin
                    send_command(CMD_LOOKUP, ctr_x + jitter(6), ctr_y + jitter(6));
                end else if (pick < 17) begin
                    send_command(CMD_LOOKUP, $urandom, $urandom);
                end else begin
                    send_command(CMD_LOOKUP, near_corner(), near_corner());
                end
            end
        end
    endtask

    initial begin
        mirror = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_command <= CMD_RECENTER;
        s_cell_x  <= '0;
        s_cell_y  <= '0;
        m_ready   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 59;

        // Lookups on the freshly cleared table find nothing.
        send_command(CMD_LOOKUP, 0, 0);
        send_command(CMD_LOOKUP, -1, -1);

        // First window at the origin. Once filled, the table is full, so a
        // miss has to go a whole lap before it gives up.
        send_command(CMD_RECENTER, 0, 0);
        send_command(CMD_LOOKUP, 0, 0);
        send_command(CMD_LOOKUP, 4, 4);
        send_command(CMD_LOOKUP, -4, -4);
        send_command(CMD_LOOKUP, 5, 0);
        send_command(CMD_LOOKUP, 0, -5);

        // Partial move: cells still in reach stay, the rest are evicted and
        // the overlap is inserted again over itself.
        send_command(CMD_RECENTER, 3, -2);
        send_command(CMD_LOOKUP, -1, 0);
        send_command(CMD_LOOKUP, -2, 0);
        send_command(CMD_LOOKUP, 7, 2);

        // Windows that straddle the signed wrap of the coordinates.
        send_command(CMD_RECENTER, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(CMD_LOOKUP, 32'h8000_0003, 32'h7FFF_FFFC);
        send_command(CMD_LOOKUP, 32'h7FFF_FFFB, 32'h8000_0004);
        send_command(CMD_LOOKUP, 32'h8000_0004, 32'h8000_0000);
        send_command(CMD_RECENTER, 32'h8000_0001, 32'h7FFF_FFFE);
        send_command(CMD_LOOKUP, 32'h7FFF_FFFD, 32'h7FFF_FFFA);

        // Window around minus one, crossing zero on both axes.
        send_command(CMD_RECENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_LOOKUP, 3, 3);
        send_command(CMD_LOOKUP, -5, -5);
        send_command(CMD_LOOKUP, 4, -1);

        // Most negative x against most positive y.
        send_command(CMD_RECENTER, 32'h8000_0000, 32'h7FFF_FFFF);
        send_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(CMD_LOOKUP, 0, 0);

        run_random(510);

        send_idle_pct = 59;
        recv_idle_pct = 24;
        run_random(510);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(505);

        s_valid <= 1'b0;
        while (mirror.due.size() != 0) begin
            @(posedge aclk);
        end
        // Stay a while to catch any stray word after the last expected one.
        repeat (300) @(posedge aclk);

        if (mirror.bad_words == 0 && mirror.due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
